// ===== src/image_framer_with_crc32_macros.svh =====
// assertion macros used by the checker file
// expects clk and arst_n to be visible where a macro is used
`ifndef IMAGE_FRAMER_WITH_CRC32_MACROS_SVH
`define IMAGE_FRAMER_WITH_CRC32_MACROS_SVH

// same-cycle implication, masked during reset
`define IFC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("image framer check failed");

// next-cycle implication, masked during reset
`define IFC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("image framer check failed");

`endif

// ===== src/ifc_pkg.sv =====
// shared types, constants and functions of the image framer
// no dependencies
package ifc_pkg;

	localparam int unsigned HDR_SIZE  = 28;
	localparam int unsigned HDR_IDX_W = $clog2(HDR_SIZE);
	localparam int unsigned TRL_SIZE  = 4;

	localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_SIZE - 1);
	localparam logic [1:0]           TRL_LAST = 2'(TRL_SIZE - 1);

	localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
	localparam logic [31:0] HDR_MAGIC   = 32'h4946_454E;
	localparam logic [15:0] HDR_VERSION = 16'h0001;
	localparam logic [31:0] HDR_WSIZE   = 32'(HDR_SIZE);
	localparam logic [31:0] TOTAL_EXTRA = 32'(HDR_SIZE + TRL_SIZE);

	localparam logic [31:0] RST_PAYLOAD_LENGTH  = 32'h0000_0000;
	localparam logic [7:0]  RST_ARCH_CODE       = 8'h10;
	localparam logic [31:0] RST_SERVICE_VERSION = 32'h0001_0000;

	typedef enum logic [1:0] {
		REG_PAYLOAD_LENGTH  = 2'd0,
		REG_ARCH_CODE       = 2'd1,
		REG_SERVICE_VERSION = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_NONE,
		PH_HDR,
		PH_DATA,
		PH_TRL
	} phase_t;

	typedef struct packed {
		logic [31:0] payload_length;
		logic [7:0]  arch_code;
		logic [31:0] service_version;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last_of_run;
		logic       frame_end;
	} emit_t;

	typedef struct packed {
		logic       upd;
		logic       clr;
		logic [7:0] data;
	} crc_ctl_t;

	// one byte of reflected crc-32, bit steps unrolled
	function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
		end
		return r;
	endfunction

	// header byte at offset idx, little-endian words
	function automatic logic [7:0] hdr_byte(logic [HDR_IDX_W-1:0] idx, logic [7:0] arch,
		logic [31:0] sver, logic [31:0] total);
		logic [7:0] b;
		unique case (idx)
			5'd0:  b = HDR_MAGIC[7:0];
			5'd1:  b = HDR_MAGIC[15:8];
			5'd2:  b = HDR_MAGIC[23:16];
			5'd3:  b = HDR_MAGIC[31:24];
			5'd4:  b = HDR_VERSION[7:0];
			5'd5:  b = HDR_VERSION[15:8];
			5'd6:  b = arch;
			5'd8:  b = HDR_WSIZE[7:0];
			5'd9:  b = HDR_WSIZE[15:8];
			5'd10: b = HDR_WSIZE[23:16];
			5'd11: b = HDR_WSIZE[31:24];
			5'd20: b = sver[7:0];
			5'd21: b = sver[15:8];
			5'd22: b = sver[23:16];
			5'd23: b = sver[31:24];
			5'd24: b = total[7:0];
			5'd25: b = total[15:8];
			5'd26: b = total[23:16];
			5'd27: b = total[31:24];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== src/ifc_crc.sv =====
// running crc-32 register of the image framer
// depends on ifc_pkg
module ifc_crc import ifc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  crc_ctl_t    ctl,
	output logic [31:0] crc
);

	logic [31:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctl.clr) begin
			crc_q <= CRC_INIT;
		end else if (ctl.upd) begin
			crc_q <= crc_byte(crc_q, ctl.data);
		end
	end

	assign crc = crc_q;

endmodule

// ===== src/ifc_seq.sv =====
// input stage and byte sequencer: header, payload byte, crc trailer
// depends on ifc_pkg
module ifc_seq import ifc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last_item,
	input  cfg_t        cfg,
	input  logic [31:0] crc,
	input  logic        out_ready,
	output emit_t       emit,
	output crc_ctl_t    crc_ctl
);

	logic                 valid_s1;
	logic [7:0]           data_s1;
	logic                 has_s1;
	logic                 last_s1;
	logic                 mid_q;
	phase_t               phase_q;
	logic [HDR_IDX_W-1:0] idx_q;
	logic                 in_frame_q;

	phase_t               start_phase;
	phase_t               cur_phase;
	logic [HDR_IDX_W-1:0] cur_idx;
	phase_t               nxt_phase;
	logic [HDR_IDX_W-1:0] nxt_idx;
	logic                 item_done;
	logic                 go;
	logic                 in_accept;
	logic [31:0]          total;
	logic [31:0]          crc_out;
	logic [7:0]           byte_c;
	logic                 frame_end_c;

	// position within the current item
	always_comb begin
		if (!in_frame_q) begin
			start_phase = PH_HDR;
		end else if (has_s1) begin
			start_phase = PH_DATA;
		end else if (last_s1) begin
			start_phase = PH_TRL;
		end else begin
			start_phase = PH_NONE;
		end
		cur_phase = mid_q ? phase_q : start_phase;
		cur_idx   = mid_q ? idx_q : '0;
	end

	// next position
	always_comb begin
		nxt_phase = cur_phase;
		nxt_idx   = cur_idx;
		item_done = 1'b0;
		unique case (cur_phase)
			PH_HDR: begin
				if (cur_idx != HDR_LAST) begin
					nxt_idx = cur_idx + 1'b1;
				end else begin
					nxt_idx = '0;
					priority if (has_s1) begin
						nxt_phase = PH_DATA;
					end else if (last_s1) begin
						nxt_phase = PH_TRL;
					end else begin
						item_done = 1'b1;
					end
				end
			end
			PH_DATA: begin
				nxt_idx = '0;
				if (last_s1) begin
					nxt_phase = PH_TRL;
				end else begin
					item_done = 1'b1;
				end
			end
			PH_TRL: begin
				if (cur_idx[1:0] != TRL_LAST) begin
					nxt_idx = cur_idx + 1'b1;
				end else begin
					item_done = 1'b1;
				end
			end
			PH_NONE: item_done = 1'b1;
		endcase
	end

	// emitted byte and crc control
	always_comb begin
		total       = cfg.payload_length + TOTAL_EXTRA;
		crc_out     = ~crc;
		frame_end_c = (cur_phase == PH_TRL) && (cur_idx[1:0] == TRL_LAST);
		unique case (cur_phase)
			PH_HDR:  byte_c = hdr_byte(cur_idx, cfg.arch_code, cfg.service_version, total);
			PH_DATA: byte_c = data_s1;
			PH_TRL:  byte_c = crc_out[{cur_idx[1:0], 3'b000} +: 8];
			PH_NONE: byte_c = 8'h00;
		endcase
		go = valid_s1 && ((cur_phase == PH_NONE) || out_ready);

		emit.valid       = valid_s1 && (cur_phase != PH_NONE);
		emit.data        = byte_c;
		emit.last_of_run = item_done;
		emit.frame_end   = frame_end_c;

		crc_ctl.upd  = go && ((cur_phase == PH_HDR) || (cur_phase == PH_DATA));
		crc_ctl.clr  = go && frame_end_c;
		crc_ctl.data = byte_c;
	end

	assign in_stall  = valid_s1 && !(go && item_done);
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			mid_q      <= 1'b0;
			phase_q    <= PH_NONE;
			idx_q      <= '0;
			in_frame_q <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (go && item_done) begin
				valid_s1 <= 1'b0;
			end
			if (go) begin
				mid_q   <= !item_done;
				phase_q <= nxt_phase;
				idx_q   <= nxt_idx;
				if (frame_end_c) begin
					in_frame_q <= 1'b0;
				end else if (cur_phase == PH_HDR) begin
					in_frame_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			data_s1 <= data_byte;
			has_s1  <= has_byte;
			last_s1 <= last_item;
		end
	end

endmodule

// ===== src/image_framer_with_crc32.sv =====
// image framer: 28-byte header, payload bytes, crc-32 trailer, one byte per transaction
// first result is registered from the input stage into the output register; the output register moves one
// byte per cycle while out_stall is low, so an item holds the input stage until all its results are taken:
// one result for a plain payload byte, up to 33 for a single-item frame
// reset: registers to their defaults, crc all ones, no frame open, both stages empty
module image_framer_with_crc32 import ifc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last_item,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        frame_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t        cfg_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_of_run_q;
	logic        frame_end_q;
	logic        out_ready;
	emit_t       emit;
	crc_ctl_t    crc_ctl;
	logic [31:0] crc;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.payload_length  <= RST_PAYLOAD_LENGTH;
			cfg_q.arch_code       <= RST_ARCH_CODE;
			cfg_q.service_version <= RST_SERVICE_VERSION;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PAYLOAD_LENGTH:  cfg_q.payload_length  <= cfg_data;
				REG_ARCH_CODE:       cfg_q.arch_code       <= cfg_data[7:0];
				REG_SERVICE_VERSION: cfg_q.service_version <= cfg_data;
				default: ;
			endcase
		end
	end

	ifc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.has_byte  (has_byte),
		.last_item (last_item),
		.cfg       (cfg_q),
		.crc       (crc),
		.out_ready (out_ready),
		.emit      (emit),
		.crc_ctl   (crc_ctl)
	);

	ifc_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.crc    (crc)
	);

	// output register takes a new byte whenever it is empty or being drained
	assign out_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && emit.valid) begin
			out_byte_q    <= emit.data;
			last_of_run_q <= emit.last_of_run;
			frame_end_q   <= emit.frame_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_of_run_q;
	assign frame_end   = frame_end_q;

endmodule

// ===== src/ifc_checker.sv =====
// port-level checks of the image framer and the bind that attaches them
// depends on ifc_pkg and image_framer_with_crc32_macros.svh
`include "image_framer_with_crc32_macros.svh"

module ifc_checker import ifc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic        last_of_run,
	input logic        frame_end
);

	logic       out_xfer;
	logic       frame_start_q;
	logic [5:0] frame_cnt_q;

	assign out_xfer = out_valid && !out_stall;

	// first byte of each frame and a saturating count of bytes seen in it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_start_q <= 1'b1;
			frame_cnt_q   <= '0;
		end else if (out_xfer) begin
			frame_start_q <= frame_end;
			if (frame_end) begin
				frame_cnt_q <= '0;
			end else if (frame_cnt_q != 6'h3F) begin
				frame_cnt_q <= frame_cnt_q + 1'b1;
			end
		end
	end

	`IFC_ASSERT_NOW(a_end_closes_run, out_valid && frame_end, last_of_run)
	`IFC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte))
	`IFC_ASSERT_NOW(a_frame_magic, out_valid && frame_start_q, out_byte == HDR_MAGIC[7:0])
	`IFC_ASSERT_NOW(a_frame_min_len, out_valid && frame_end,
		frame_cnt_q >= 6'(HDR_SIZE + TRL_SIZE - 1))

endmodule

bind image_framer_with_crc32 ifc_checker u_ifc_checker (.*);
